>>> rtl/lewh_pkg.sv
// ---------------------------------------------------------------------------
// lewh_pkg
// shared types and constants of the line editor with history recall
// ---------------------------------------------------------------------------
package lewh_pkg;

  localparam int LINE_CAP_DEF   = 40;
  localparam int HIST_DEPTH_DEF = 8;
  localparam int REP_W          = 6;

  // key codes
  localparam logic [7:0] K_CR    = 8'h0D;
  localparam logic [7:0] K_DEL   = 8'h14;
  localparam logic [7:0] K_LEFT  = 8'h9D;
  localparam logic [7:0] K_RIGHT = 8'h1D;
  localparam logic [7:0] K_UP    = 8'h91;
  localparam logic [7:0] K_DOWN  = 8'h11;
  localparam logic [7:0] K_HOME  = 8'h13;
  localparam logic [7:0] K_CLR   = 8'h93;
  localparam logic [7:0] K_SPACE = 8'h20;
  localparam logic [7:0] PR_LO   = 8'h20;
  localparam logic [7:0] PR_HI   = 8'h7E;
  localparam logic [7:0] EX_LO   = 8'hDB;
  localparam logic [7:0] EX_HI   = 8'hDD;

  // result kinds
  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    C_HOLD,
    C_INS,
    C_APP,
    C_DEL,
    C_SHL
  } cell_op_t;

  typedef struct packed {
    cell_op_t   op;
    logic [7:0] key;
  } cell_ctl_t;

  // one symbol handed to the result packer
  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       code;
    logic [REP_W-1:0] cnt;
  } sym_t;

endpackage

>>> rtl/line_editor_with_history_core.sv
// ---------------------------------------------------------------------------
// line_editor_with_history_core
// keystroke line editor with a ring of recalled lines
// ---------------------------------------------------------------------------
// usage
// - input channel: one keystroke item on in_key_code, taken when in_valid is
//   high and in_stall is low; in_stall is high while a keystroke is at work
// - result channel: out_kind / out_code / out_repeat_res / out_last, taken
//   when out_valid is high and out_stall is low; out_last flags the final
//   result of a keystroke, a keystroke that is refused gives none
// - the sequencer walks one keystroke at a time; the chain of cells shifts
//   one position per cycle while its step advances, not while it waits to emit
// - a stalled receiver holds the output register and the packer; the chain
//   waits on the step that would emit
// - reset (rst_n low, synchronous) empties the line, the browse depth and
//   the history ring; stored characters need no clearing
// ---------------------------------------------------------------------------
module line_editor_with_history_core
  import lewh_pkg::*;
#(
  parameter int LINE_CAP      = LINE_CAP_DEF,
  parameter int HISTORY_DEPTH = HIST_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_key_code,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_code,
  output logic [REP_W-1:0] out_repeat_res,
  output logic             out_last
);

  localparam int LEN_W  = $clog2(LINE_CAP + 1);
  localparam int SLOT_W = $clog2(HISTORY_DEPTH);
  localparam int DEP_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W  = DEP_W + 1;
  localparam int WORDS  = HISTORY_DEPTH * LINE_CAP;
  localparam int ADDR_W = $clog2(WORDS);

  localparam logic [LEN_W-1:0]  CAP_V   = LEN_W'(LINE_CAP);
  localparam logic [LEN_W-1:0]  LAST_IX = LEN_W'(LINE_CAP - 1);
  localparam logic [DEP_W-1:0]  HD_V    = DEP_W'(HISTORY_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LS = SLOT_W'(HISTORY_DEPTH - 1);
  localparam logic [SUM_W-1:0]  HD_S    = SUM_W'(HISTORY_DEPTH);

  // sequencer states
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ECHO  = 9'b000000010,
    S_PRE   = 9'b000000100,
    S_LOAD  = 9'b000001000,
    S_ROT   = 9'b000010000,
    S_SPC   = 9'b000100000,
    S_POST  = 9'b001000000,
    S_EMPTY = 9'b010000000,
    S_FLUSH = 9'b100000000
  } state_t;

  typedef enum logic [2:0] {
    M_ECHO,
    M_SUBMIT,
    M_HOME,
    M_REDRAW,
    M_REPLACE
  } mode_t;

  state_t             state_r, state_nxt;
  mode_t              mode_r, mode_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [LEN_W-1:0]   cur_r, cur_nxt;
  logic [DEP_W-1:0]   depth_r, depth_nxt;
  logic [SLOT_W-1:0]  wslot_r, wslot_nxt;
  logic [DEP_W-1:0]   hvalid_r, hvalid_nxt;
  logic [LEN_W-1:0]   hlen_r [HISTORY_DEPTH];
  logic               hlen_we;
  logic [7:0]         code_r, code_nxt;
  logic [LEN_W-1:0]   pre_r, pre_nxt;
  logic [LEN_W-1:0]   nrot_r, nrot_nxt;
  logic [LEN_W-1:0]   spc_r, spc_nxt;
  logic [LEN_W-1:0]   post_r, post_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [LEN_W-1:0]   idx_r, idx_nxt;
  logic               primed_r, primed_nxt;

  // chain signals
  logic [7:0]         cell_data [LINE_CAP];
  logic [7:0]         chain_tail;
  cell_ctl_t          cell_ctl;

  // packer link
  logic               sym_valid;
  sym_t               sym;
  logic               sym_take;
  logic               flush;
  logic               flush_done;

  // history memory link
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [7:0]         mem_rdata;
  logic [LEN_W-1:0]   rd_idx;

  // helpers
  logic               accept;
  logic               is_print;
  logic               adv;
  logic               emit;
  logic [DEP_W-1:0]   rep_depth;
  logic [SUM_W-1:0]   slot_sum;
  logic [SLOT_W-1:0]  rep_slot;
  logic [LEN_W-1:0]   rep_n;
  logic [LEN_W-1:0]   tail_cnt;
  logic [LEN_W:0]     post_cnt;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign is_print = (in_key_code >= PR_LO && in_key_code <= PR_HI)
                    || (in_key_code >= EX_LO && in_key_code <= EX_HI);

  // ring slot for the depth a recall will land on
  always_comb begin
    if (in_key_code == K_UP) begin
      rep_depth = depth_r + DEP_W'(1);
    end else if (in_key_code == K_DOWN) begin
      rep_depth = depth_r - DEP_W'(1);
    end else begin
      rep_depth = '0;
    end
    slot_sum = SUM_W'(wslot_r) + HD_S - SUM_W'(rep_depth);
    if (slot_sum >= HD_S) begin
      slot_sum = slot_sum - HD_S;
    end
    rep_slot = SLOT_W'(slot_sum);
    rep_n    = (rep_depth == '0) ? '0 : hlen_r[rep_slot];
    tail_cnt = (len_r > rep_n) ? (len_r - rep_n) : '0;
    // redraw ends with the cursor walked back from one past the line end
    post_cnt = {1'b0, len_r} + (LEN_W + 1)'(1) - {1'b0, cur_r};
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    len_nxt      = len_r;
    cur_nxt      = cur_r;
    depth_nxt    = depth_r;
    wslot_nxt    = wslot_r;
    hvalid_nxt   = hvalid_r;
    code_nxt     = code_r;
    pre_nxt      = pre_r;
    nrot_nxt     = nrot_r;
    spc_nxt      = spc_r;
    post_nxt     = post_r;
    base_nxt     = base_r;
    idx_nxt      = idx_r;
    primed_nxt   = primed_r;
    hlen_we      = 1'b0;
    cell_ctl.op  = C_HOLD;
    cell_ctl.key = in_key_code;
    sym_valid    = 1'b0;
    sym.kind     = KIND_ECHO;
    sym.code     = code_r;
    sym.cnt      = REP_W'(1);
    flush        = 1'b0;
    mem_we       = 1'b0;
    adv          = 1'b0;
    emit         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          code_nxt   = in_key_code;
          mode_nxt   = M_ECHO;
          idx_nxt    = '0;
          primed_nxt = 1'b0;
          state_nxt  = S_ECHO;
          priority if (in_key_code == K_CR) begin
            mode_nxt  = M_SUBMIT;
            nrot_nxt  = len_r;
            base_nxt  = ADDR_W'(wslot_r) * ADDR_W'(LINE_CAP);
            if (len_r != '0) begin
              hlen_we   = 1'b1;
              wslot_nxt = (wslot_r == SLOT_LS) ? '0 : wslot_r + SLOT_W'(1);
              if (hvalid_r != HD_V) begin
                hvalid_nxt = hvalid_r + DEP_W'(1);
              end
            end
            len_nxt   = '0;
            cur_nxt   = '0;
            depth_nxt = '0;
          end else if (in_key_code == K_UP || in_key_code == K_DOWN
                       || in_key_code == K_CLR) begin
            if ((in_key_code == K_UP && depth_r < hvalid_r)
                || (in_key_code == K_DOWN && depth_r != '0)
                || in_key_code == K_CLR) begin
              if (in_key_code != K_CLR) begin
                depth_nxt = rep_depth;
              end
              mode_nxt  = M_REPLACE;
              pre_nxt   = cur_r;
              nrot_nxt  = rep_n;
              base_nxt  = ADDR_W'(rep_slot) * ADDR_W'(LINE_CAP);
              spc_nxt   = tail_cnt;
              post_nxt  = tail_cnt;
              len_nxt   = rep_n;
              cur_nxt   = rep_n;
              state_nxt = S_PRE;
            end else begin
              state_nxt = S_FLUSH;
            end
          end else if (in_key_code == K_HOME) begin
            mode_nxt  = M_HOME;
            pre_nxt   = cur_r;
            cur_nxt   = '0;
            state_nxt = S_PRE;
          end else if (in_key_code == K_LEFT) begin
            if (cur_r != '0) begin
              cur_nxt = cur_r - LEN_W'(1);
            end else begin
              state_nxt = S_FLUSH;
            end
          end else if (in_key_code == K_RIGHT) begin
            if (cur_r < len_r) begin
              cur_nxt = cur_r + LEN_W'(1);
            end else begin
              state_nxt = S_FLUSH;
            end
          end else if (in_key_code == K_DEL) begin
            if (cur_r == '0) begin
              state_nxt = S_FLUSH;
            end else begin
              len_nxt = len_r - LEN_W'(1);
              cur_nxt = cur_r - LEN_W'(1);
              if (cur_r != len_r) begin
                // close the gap, then redraw from the line start
                cell_ctl.op = C_DEL;
                mode_nxt    = M_REDRAW;
                pre_nxt     = cur_r;
                nrot_nxt    = len_r - LEN_W'(1);
                spc_nxt     = LEN_W'(1);
                post_nxt    = LEN_W'(post_cnt);
                state_nxt   = S_PRE;
              end
            end
          end else if (is_print) begin
            if (len_r == CAP_V) begin
              state_nxt = S_FLUSH;
            end else begin
              len_nxt = len_r + LEN_W'(1);
              cur_nxt = cur_r + LEN_W'(1);
              if (cur_r == len_r) begin
                cell_ctl.op = C_APP;
              end else begin
                cell_ctl.op = C_INS;
                mode_nxt    = M_REDRAW;
                pre_nxt     = cur_r;
                nrot_nxt    = len_r + LEN_W'(1);
                spc_nxt     = LEN_W'(1);
                post_nxt    = LEN_W'(post_cnt);
                state_nxt   = S_PRE;
              end
            end
          end else begin
            // anything else is only echoed
            state_nxt = S_ECHO;
          end
        end
      end

      S_ECHO: begin
        sym_valid = 1'b1;
        if (sym_take) begin
          if (mode_r == M_SUBMIT) begin
            state_nxt = (nrot_r == '0) ? S_EMPTY : S_ROT;
          end else begin
            state_nxt = S_FLUSH;
          end
        end
      end

      S_PRE: begin
        sym.code  = K_LEFT;
        sym.cnt   = REP_W'(pre_r);
        sym_valid = (pre_r != '0);
        if (pre_r == '0 || sym_take) begin
          unique case (mode_r)
            M_REDRAW:  state_nxt = S_ROT;
            M_REPLACE: state_nxt = (nrot_r != '0) ? S_LOAD : S_SPC;
            default:   state_nxt = S_FLUSH;
          endcase
        end
      end

      S_ROT: begin
        // whole chain turns once, cell 0 shows each line byte in order
        emit      = (idx_r < nrot_r);
        sym.kind  = (mode_r == M_SUBMIT) ? KIND_LINE : KIND_ECHO;
        sym.code  = cell_data[0];
        sym_valid = emit;
        adv       = !emit || sym_take;
        if (adv) begin
          cell_ctl.op = C_SHL;
          mem_we      = (mode_r == M_SUBMIT) && emit;
          if (idx_r == LAST_IX) begin
            idx_nxt   = '0;
            state_nxt = (mode_r == M_SUBMIT) ? S_FLUSH : S_SPC;
          end else begin
            idx_nxt = idx_r + LEN_W'(1);
          end
        end
      end

      S_LOAD: begin
        // history bytes shift in at the chain tail, one per step
        if (!primed_r) begin
          primed_nxt = 1'b1;
        end else begin
          emit      = (idx_r < nrot_r);
          sym.code  = mem_rdata;
          sym_valid = emit;
          adv       = !emit || sym_take;
          if (adv) begin
            cell_ctl.op = C_SHL;
            if (idx_r == LAST_IX) begin
              idx_nxt   = '0;
              state_nxt = S_SPC;
            end else begin
              idx_nxt = idx_r + LEN_W'(1);
            end
          end
        end
      end

      S_SPC: begin
        sym.code  = K_SPACE;
        sym.cnt   = REP_W'(spc_r);
        sym_valid = (spc_r != '0);
        if (spc_r == '0 || sym_take) begin
          state_nxt = S_POST;
        end
      end

      S_POST: begin
        sym.code  = K_LEFT;
        sym.cnt   = REP_W'(post_r);
        sym_valid = (post_r != '0);
        if (post_r == '0 || sym_take) begin
          state_nxt = S_FLUSH;
        end
      end

      S_EMPTY: begin
        sym.kind  = KIND_EMPTY;
        sym.code  = 8'h00;
        sym_valid = 1'b1;
        if (sym_take) begin
          state_nxt = S_FLUSH;
        end
      end

      S_FLUSH: begin
        flush = 1'b1;
        if (flush_done) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // read one ahead when the load step advances
  assign rd_idx     = (state_r == S_LOAD && adv && idx_r != LAST_IX)
                      ? idx_r + LEN_W'(1) : idx_r;
  assign mem_raddr  = base_r + ADDR_W'(rd_idx);
  assign chain_tail = (state_r == S_LOAD) ? mem_rdata : cell_data[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mode_r   <= M_ECHO;
      len_r    <= '0;
      cur_r    <= '0;
      depth_r  <= '0;
      wslot_r  <= '0;
      hvalid_r <= '0;
      idx_r    <= '0;
      primed_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      len_r    <= len_nxt;
      cur_r    <= cur_nxt;
      depth_r  <= depth_nxt;
      wslot_r  <= wslot_nxt;
      hvalid_r <= hvalid_nxt;
      idx_r    <= idx_nxt;
      primed_r <= primed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    pre_r  <= pre_nxt;
    nrot_r <= nrot_nxt;
    spc_r  <= spc_nxt;
    post_r <= post_nxt;
    base_r <= base_nxt;
    if (hlen_we) begin
      hlen_r[wslot_r] <= len_r;
    end
  end

  // line buffer: a chain of character cells
  for (genvar i = 0; i < LINE_CAP; i++) begin : g_cell
    logic [7:0] left_in;
    logic [7:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = 8'h00;
    end else begin : g_mid
      assign left_in = cell_data[i-1];
    end
    if (i == LINE_CAP - 1) begin : g_last
      assign right_in = chain_tail;
    end else begin : g_inner
      assign right_in = cell_data[i+1];
    end
    lewh_cell #(
      .LEN_W (LEN_W),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .cur        (cur_r),
      .len        (len_r),
      .from_left  (left_in),
      .from_right (right_in),
      .data       (cell_data[i])
    );
  end

  lewh_hist #(
    .WORDS  (WORDS),
    .ADDR_W (ADDR_W)
  ) u_hist (
    .clk   (clk),
    .we    (mem_we),
    .waddr (base_r + ADDR_W'(idx_r)),
    .wdata (cell_data[0]),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lewh_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .sym_valid      (sym_valid),
    .sym            (sym),
    .sym_take       (sym_take),
    .flush          (flush),
    .flush_done     (flush_done),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_code       (out_code),
    .out_repeat_res (out_repeat_res),
    .out_last       (out_last)
  );

`ifndef SYNTHESIS
  // cursor stays inside the line
  a_cur_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= len_r)
    else $error("cursor past line end");

  // browse depth never goes past the filled history
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= hvalid_r && hvalid_r <= HD_V)
    else $error("browse depth beyond history");

  // history fill count only grows
  a_hvalid_mono: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> hvalid_r >= $past(hvalid_r))
    else $error("history count shrank");

  // history writes happen only while a submit walks the chain
  a_wr_in_submit: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_ROT && mode_r == M_SUBMIT && idx_r < nrot_r))
    else $error("stray history write");
`endif

endmodule

>>> rtl/lewh_cell.sv
// ---------------------------------------------------------------------------
// lewh_cell
// one character cell of the line buffer chain
// ---------------------------------------------------------------------------
module lewh_cell
  import lewh_pkg::*;
#(
  parameter int LEN_W = 6,
  parameter int IDX   = 0
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [LEN_W-1:0] cur,
  input  logic [LEN_W-1:0] len,
  input  logic [7:0]       from_left,
  input  logic [7:0]       from_right,
  output logic [7:0]       data
);

  localparam logic [LEN_W-1:0] POS  = LEN_W'(IDX);
  localparam logic [LEN_W-1:0] POS1 = LEN_W'(IDX + 1);

  logic [7:0] data_r;
  logic [7:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (ctl.op)
      C_HOLD: data_nxt = data_r;
      C_INS: begin
        if (POS == cur) begin
          data_nxt = ctl.key;
        end else if (POS > cur && POS <= len) begin
          data_nxt = from_left;
        end
      end
      C_APP: begin
        if (POS == len) begin
          data_nxt = ctl.key;
        end
      end
      C_DEL: begin
        if (POS1 >= cur && POS1 < len) begin
          data_nxt = from_right;
        end
      end
      C_SHL:   data_nxt = from_right;
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

>>> rtl/lewh_hist.sv
// ---------------------------------------------------------------------------
// lewh_hist
// history line memory, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module lewh_hist #(
  parameter int WORDS  = 320,
  parameter int ADDR_W = 9
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [WORDS];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/lewh_emit.sv
// ---------------------------------------------------------------------------
// lewh_emit
// packs echo runs into repeat counts and holds the output register
// ---------------------------------------------------------------------------
module lewh_emit
  import lewh_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             sym_valid,
  input  sym_t             sym,
  output logic             sym_take,
  input  logic             flush,
  output logic             flush_done,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_code,
  output logic [REP_W-1:0] out_repeat_res,
  output logic             out_last
);

  logic             pend_valid_r, pend_valid_nxt;
  sym_t             pend_r, pend_nxt;
  logic             ov_r, ov_nxt;
  logic [1:0]       okind_r, okind_nxt;
  logic [7:0]       ocode_r, ocode_nxt;
  logic [REP_W-1:0] orep_r, orep_nxt;
  logic             olast_r, olast_nxt;
  logic             out_free;
  logic             merge;
  logic             push;

  always_comb begin
    out_free   = !ov_r || !out_stall;
    merge      = pend_valid_r && sym.kind == KIND_ECHO && pend_r.kind == KIND_ECHO
                 && pend_r.code == sym.code;
    sym_take   = sym_valid && (merge || !pend_valid_r || out_free);
    flush_done = flush && (!pend_valid_r || out_free);
    push       = (sym_take && !merge && pend_valid_r) || (flush && pend_valid_r && out_free);

    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    if (sym_take) begin
      if (merge) begin
        pend_nxt.cnt = pend_r.cnt + sym.cnt;
      end else begin
        pend_nxt       = sym;
        pend_valid_nxt = 1'b1;
      end
    end else if (flush && out_free) begin
      pend_valid_nxt = 1'b0;
    end

    ov_nxt    = ov_r;
    okind_nxt = okind_r;
    ocode_nxt = ocode_r;
    orep_nxt  = orep_r;
    olast_nxt = olast_r;
    if (push) begin
      ov_nxt    = 1'b1;
      okind_nxt = pend_r.kind;
      ocode_nxt = pend_r.code;
      orep_nxt  = pend_r.cnt;
      olast_nxt = flush;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      ov_r         <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      ov_r         <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r  <= pend_nxt;
    okind_r <= okind_nxt;
    ocode_r <= ocode_nxt;
    orep_r  <= orep_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid      = ov_r;
  assign out_kind       = okind_r;
  assign out_code       = ocode_r;
  assign out_repeat_res = orep_r;
  assign out_last       = olast_r;

endmodule

>>> tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// keystroke stream into the line editor core, results checked against a
// behavioral model of line, cursor and recall ring kept in the bench
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import lewh_pkg::*;

  localparam int CAP   = LINE_CAP_DEF;
  localparam int DEPTH = HIST_DEPTH_DEF;
  localparam int GAP_MAX = 12;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       code;
    logic [REP_W-1:0] rep;
    logic             last;
  } echo_rec_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_key_code = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_kind;
  logic [7:0]       out_code;
  logic [REP_W-1:0] out_repeat_res;
  logic             out_last;

  line_editor_with_history_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_key_code(in_key_code),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_code(out_code), .out_repeat_res(out_repeat_res), .out_last(out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // editor state mirrored in the bench
  logic [7:0] ln [CAP];
  int         ln_len, cur, depth;
  logic [7:0] ring [DEPTH][CAP];
  int         ring_len [DEPTH];
  int         ring_wr, ring_cnt;

  echo_rec_t  step_res [$];   // results of the keystroke being worked out
  echo_rec_t  expected [$];   // results the core still owes
  logic [7:0] keys [$];       // keystrokes waiting for the driver
  int         errors = 0;
  bit         sent_all = 1'b0;

  function automatic void put_rec(logic [1:0] k, logic [7:0] c);
    echo_rec_t r;
    r.kind = k; r.code = c; r.rep = REP_W'(1); r.last = 1'b0;
    step_res.push_back(r);
  endfunction

  // same echo code as the previous result joins it, up to 63 repeats
  function automatic void emit_echo(logic [7:0] c);
    int n;
    n = step_res.size();
    if (n > 0 && step_res[n-1].kind == KIND_ECHO && step_res[n-1].code == c &&
        step_res[n-1].rep < 63)
      step_res[n-1].rep++;
    else
      put_rec(KIND_ECHO, c);
  endfunction

  function automatic void emit_n(logic [7:0] c, int n);
    for (int i = 0; i < n; i++) emit_echo(c);
  endfunction

  function automatic void repaint_line(int from, int target);
    emit_n(K_LEFT, from);
    for (int i = 0; i < ln_len; i++) emit_echo(ln[i]);
    emit_echo(K_SPACE);
    emit_n(K_LEFT, ln_len + 1 - target);
  endfunction

  // swap the line for the ring entry at the current depth, depth 0 = empty
  function automatic void load_line();
    int n, slot, old;
    n = 0; old = ln_len;
    emit_n(K_LEFT, cur);
    if (depth != 0) begin
      slot = (ring_wr + DEPTH - depth) % DEPTH;
      n = ring_len[slot];
      for (int i = 0; i < n; i++) begin
        ln[i] = ring[slot][i];
        emit_echo(ln[i]);
      end
    end
    if (old > n) begin
      emit_n(K_SPACE, old - n);
      emit_n(K_LEFT, old - n);
    end
    ln_len = n; cur = n;
  endfunction

  function automatic void predict_key(logic [7:0] c);
    int keep;
    step_res.delete();
    if (c == K_CR) begin
      emit_echo(K_CR);
      if (ln_len == 0) put_rec(KIND_EMPTY, 8'h00);
      else begin
        for (int i = 0; i < ln_len; i++) begin
          put_rec(KIND_LINE, ln[i]);
          ring[ring_wr][i] = ln[i];
        end
        ring_len[ring_wr] = ln_len;
        ring_wr = (ring_wr + 1) % DEPTH;
        if (ring_cnt < DEPTH) ring_cnt++;
      end
      ln_len = 0; cur = 0; depth = 0;
    end else if (c == K_UP) begin
      if (depth < ring_cnt) begin depth++; load_line(); end
    end else if (c == K_DOWN) begin
      if (depth > 0) begin depth--; load_line(); end
    end else if (c == K_HOME) begin
      emit_n(K_LEFT, cur); cur = 0;
    end else if (c == K_CLR) begin
      keep = depth; depth = 0; load_line(); depth = keep;
    end else if (c == K_LEFT) begin
      if (cur > 0) begin emit_echo(K_LEFT); cur--; end
    end else if (c == K_RIGHT) begin
      if (cur < ln_len) begin emit_echo(K_RIGHT); cur++; end
    end else if (c == K_DEL) begin
      if (cur > 0) begin
        if (cur == ln_len) begin
          ln_len--; cur--; emit_echo(K_DEL);
        end else begin
          for (int i = cur; i < ln_len; i++) ln[i-1] = ln[i];
          ln_len--;
          repaint_line(cur, cur - 1);
          cur--;
        end
      end
    end else if ((c >= PR_LO && c <= PR_HI) || (c >= EX_LO && c <= EX_HI)) begin
      if (ln_len < CAP) begin
        if (cur == ln_len) begin
          ln[ln_len] = c; ln_len++; cur++; emit_echo(c);
        end else begin
          for (int i = ln_len; i > cur; i--) ln[i] = ln[i-1];
          ln[cur] = c; ln_len++;
          repaint_line(cur, cur + 1);
          cur++;
        end
      end
    end else begin
      emit_echo(c);
    end
    if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
    foreach (step_res[i]) expected.push_back(step_res[i]);
  endfunction

  function automatic logic [7:0] rand_printable();
    if ($urandom_range(0, 9) == 0) return 8'(EX_LO + $urandom_range(0, 2));
    return 8'($urandom_range(PR_LO, PR_HI));
  endfunction

  // stimulus: directed edge cases, then mostly well-formed editing sessions
  initial begin
    logic [7:0] edit_keys [8];
    int n;
    edit_keys = '{K_LEFT, K_RIGHT, K_DEL, K_HOME, K_CLR, K_UP, K_DOWN, K_CR};
    // empty-line corner cases: nothing moves, empty submit, no history yet
    keys.push_back(K_DEL); keys.push_back(K_LEFT); keys.push_back(K_RIGHT);
    keys.push_back(K_UP); keys.push_back(K_DOWN); keys.push_back(K_HOME);
    keys.push_back(K_CR); keys.push_back(8'h00); keys.push_back(8'h09);
    keys.push_back(8'hFF);
    // full line then a dropped key, mid-line insert and delete
    for (int i = 0; i < CAP; i++) keys.push_back(i[0] ? PR_HI : PR_LO);
    keys.push_back(EX_HI);
    keys.push_back(K_LEFT); keys.push_back(K_DEL); keys.push_back(EX_LO);
    keys.push_back(K_HOME); keys.push_back(8'h7F); keys.push_back(K_CR);
    keys.push_back(K_UP); keys.push_back(K_CLR); keys.push_back(K_DOWN);
    keys.push_back(8'hAA); keys.push_back(8'h55);
    // random sessions
    n = 0;
    while (n < 195) begin
      int len;
      len = $urandom_range(0, 12);
      if ($urandom_range(0, 15) == 0) len = CAP + 2;
      for (int i = 0; i < len; i++) begin keys.push_back(rand_printable()); n++; end
      for (int i = $urandom_range(0, 6); i > 0; i--) begin
        if ($urandom_range(0, 7) == 0) keys.push_back(8'($urandom_range(0, 255)));
        else if ($urandom_range(0, 2) == 0) keys.push_back(rand_printable());
        else keys.push_back(edit_keys[$urandom_range(0, 6)]);
        n++;
      end
      keys.push_back(K_CR); n++;
    end
  end

  // reset, then the driver takes over
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver: offers the next keystroke after a random gap
  int gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_key(in_key_code);
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, GAP_MAX);
        if (gap == 0 && keys.size() > 0) begin
          in_key_code <= keys.pop_front();
        end else begin
          in_valid <= 1'b0;
          if (keys.size() == 0 && gap == 0) sent_all = 1'b1;
        end
      end else if (!in_valid) begin
        if (gap > 0) gap--;
        else if (keys.size() > 0) begin
          in_valid <= 1'b1;
          in_key_code <= keys.pop_front();
        end else sent_all = 1'b1;
      end
    end
  end

  // monitor: compare each taken result, then draw the next stall
  int hold = 0;
  int taken = 0;
  echo_rec_t want;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        taken++;
        if (expected.size() == 0) begin
          $display("%0t: unexpected result kind %0d code %h rep %0d last %0d",
                   $time, out_kind, out_code, out_repeat_res, out_last);
          errors++;
        end else begin
          want = expected.pop_front();
          if (want.kind != out_kind || want.code != out_code ||
              want.rep != out_repeat_res || want.last != out_last) begin
            $display("%0t: expected kind %0d code %h rep %0d last %0d, got %0d %h %0d %0d",
                     $time, want.kind, want.code, want.rep, want.last,
                     out_kind, out_code, out_repeat_res, out_last);
            errors++;
          end
        end
        // one long hold-off so the core backs up into its input
        if (taken == 60) hold = 400;
        else hold = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, GAP_MAX);
        out_stall <= (hold > 0);
      end else if (hold > 0) begin
        hold--;
        out_stall <= (hold > 0);
      end else out_stall <= 1'b0;
    end
  end

  // end of run: all keys in, nothing owed, then a latency drain
  initial begin
    wait (rst_n && sent_all && !in_valid);
    wait (expected.size() == 0);
    repeat (4 * CAP + 100) @(posedge clk);
    if (errors == 0 && expected.size() == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: errors");
    $finish;
  end

endmodule
